// ----- design/gdf_pkg.sv -----
// Shared types and constants for the grid decomposition factorizer.
package gdf_pkg;

    localparam int COUNT_WIDTH  = 16;
    localparam int MAX_FACTORS  = 16;
    localparam int IDX_WIDTH    = $clog2(MAX_FACTORS);
    localparam int LEN_WIDTH    = $clog2(MAX_FACTORS + 1);
    localparam int PART_WIDTH   = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DIV_CHECK,
        ST_TAIL,
        ST_SORT,
        ST_MERGE,
        ST_ASSIGN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_accept;
        logic div_next;
        logic push_tail;
        logic sort_step;
        logic sort_reset;
        logic merge;
        logic assign_dims;
        logic out_valid;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic divides;
        logic trial_done;
        logic tail_needed;
        logic sort_done;
        logic need_merge;
    } status_t;

endpackage

// ----- design/gdf_datapath.sv -----
// Datapath: remainder divider, factor list, insertion sort and merge.
module gdf_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  gdf_pkg::cmd_t                        cmd,
    output gdf_pkg::status_t                     status,
    input  logic [gdf_pkg::COUNT_WIDTH-1:0]      count_in,
    input  logic [2:0]                           mask_in,
    output logic [3*gdf_pkg::PART_WIDTH-1:0]     parts
);
    localparam int CW = gdf_pkg::COUNT_WIDTH;
    localparam int DCW = $clog2(CW + 1);

    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] div_reg, div_next;
    logic [2:0]    mask_reg;
    logic [CW-1:0] list_reg [gdf_pkg::MAX_FACTORS];
    logic [gdf_pkg::LEN_WIDTH-1:0] len_reg, head_reg, pos_reg;
    logic [gdf_pkg::LEN_WIDTH-1:0] len_next, head_next, pos_next;
    logic [3*gdf_pkg::PART_WIDTH-1:0] parts_reg, parts_next;

    // restoring divider, one quotient bit per cycle
    logic [CW-1:0]  rem_reg, quo_reg;
    logic [CW-1:0]  dvd_reg;
    logic [DCW-1:0] cnt_reg;
    logic           busy_reg;
    logic [CW:0]    trial;

    logic [1:0]  dims;
    logic [2*CW-1:0] sq;
    logic [CW-1:0]   push_val;
    logic            push_en;

    assign dims = 2'(mask_reg[0]) + 2'(mask_reg[1]) + 2'(mask_reg[2]);
    assign sq   = div_reg * div_reg;
    assign trial = {rem_reg, dvd_reg[CW-1]} - {1'b0, div_reg};

    logic [gdf_pkg::LEN_WIDTH-1:0] live;
    assign live = len_reg - head_reg;

    logic [gdf_pkg::IDX_WIDTH-1:0] pi, pim1;
    assign pi   = pos_reg[gdf_pkg::IDX_WIDTH-1:0];
    assign pim1 = pi - 1'b1;

    assign status.div_busy    = busy_reg;
    assign status.divides     = (rem_reg == '0);
    assign status.trial_done  = (sq > (2*CW)'(n_reg));
    assign status.tail_needed = (n_reg > CW'(1));
    assign status.sort_done   = (pos_reg >= len_reg);
    assign status.need_merge  = (dims != 2'd0) && (live > gdf_pkg::LEN_WIDTH'(dims));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvd_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DCW'(CW);
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvd_reg  <= n_reg;
        end
        else if (busy_reg)
        begin
            if (!trial[CW])
            begin
                rem_reg <= trial[CW-1:0];
                quo_reg <= {quo_reg[CW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[CW-2:0], dvd_reg[CW-1]};
                quo_reg <= {quo_reg[CW-2:0], 1'b0};
            end
            dvd_reg <= {dvd_reg[CW-2:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DCW'(1))
                busy_reg <= 1'b0;
        end
    end

    always_comb
    begin
        n_next    = n_reg;
        div_next  = div_reg;
        len_next  = len_reg;
        head_next = head_reg;
        pos_next  = pos_reg;
        push_en   = 1'b0;
        push_val  = div_reg;
        if (cmd.load)
        begin
            n_next    = (count_in == '0) ? CW'(1) : count_in;
            div_next  = CW'(2);
            len_next  = '0;
            head_next = '0;
        end
        if (cmd.div_accept)
        begin
            n_next  = quo_reg;
            push_en = 1'b1;
        end
        if (cmd.div_next)
            div_next = (div_reg == CW'(2)) ? CW'(3) : div_reg + CW'(2);
        if (cmd.push_tail)
        begin
            push_en  = 1'b1;
            push_val = n_reg;
        end
        if (push_en && len_reg < gdf_pkg::LEN_WIDTH'(gdf_pkg::MAX_FACTORS))
            len_next = len_reg + 1'b1;
        if (cmd.sort_reset)
            pos_next = head_reg + 1'b1;
        if (cmd.sort_step)
        begin
            if (pos_reg > head_reg && list_reg[pim1] > list_reg[pi])
                pos_next = pos_reg - 1'b1;
            else
                pos_next = pos_reg + 1'b1;
        end
        if (cmd.merge)
            head_next = head_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            head_reg <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            len_reg  <= len_next;
            head_reg <= head_next;
            pos_reg  <= pos_next;
        end
    end

    logic [gdf_pkg::IDX_WIDTH-1:0] hi;
    assign hi = head_reg[gdf_pkg::IDX_WIDTH-1:0];

    // hand out remaining factors in list order to the selected dimensions
    always_comb
    begin
        logic [gdf_pkg::LEN_WIDTH-1:0] h;
        h = head_reg;
        parts_next = '0;
        for (int d = 0; d < 3; d++)
        begin
            if (h < len_reg && mask_reg[d])
            begin
                parts_next[d*gdf_pkg::PART_WIDTH +: gdf_pkg::PART_WIDTH] =
                    gdf_pkg::PART_WIDTH'(list_reg[h[gdf_pkg::IDX_WIDTH-1:0]]);
                h = h + 1'b1;
            end
            else
                parts_next[d*gdf_pkg::PART_WIDTH +: gdf_pkg::PART_WIDTH] =
                    gdf_pkg::PART_WIDTH'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        div_reg <= div_next;
        if (cmd.load)
            mask_reg <= mask_in;
        if (push_en)
        begin
            if (len_reg < gdf_pkg::LEN_WIDTH'(gdf_pkg::MAX_FACTORS))
                list_reg[len_reg[gdf_pkg::IDX_WIDTH-1:0]] <= push_val;
            else
                list_reg[gdf_pkg::MAX_FACTORS-1] <=
                    CW'(list_reg[gdf_pkg::MAX_FACTORS-1] * push_val);
        end
        // at most one insertion-sort exchange per cycle, on a sort step
        if (cmd.sort_step && pos_reg > head_reg && list_reg[pim1] > list_reg[pi])
        begin
            list_reg[pim1] <= list_reg[pi];
            list_reg[pi]   <= list_reg[pim1];
        end
        if (cmd.merge)
            list_reg[hi + 1'b1] <= CW'(list_reg[hi + 1'b1] * list_reg[hi]);
        if (cmd.assign_dims)
            parts_reg <= parts_next;
    end

    assign parts = parts_reg;

    logic unused_ok;
    assign unused_ok = cmd.out_valid;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> busy_reg) else $error("divider did not start");
    assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= len_reg || len_reg == '0) else $error("head past list end");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge |-> !busy_reg) else $error("merge while dividing");
endmodule

// ----- design/gdf_ctrl.sv -----
// Controller state machine sequencing trial division, sort and merge.
module gdf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_fire,
    input  gdf_pkg::status_t  status,
    output gdf_pkg::cmd_t     cmd,
    output logic              idle
);
    gdf_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gdf_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gdf_pkg::ST_IDLE:      if (in_fire) state_next = gdf_pkg::ST_DIV_START;
            gdf_pkg::ST_DIV_START:
            begin
                if (status.trial_done)
                    state_next = gdf_pkg::ST_TAIL;
                else
                    state_next = gdf_pkg::ST_DIV_WAIT;
            end
            gdf_pkg::ST_DIV_WAIT:  if (!status.div_busy) state_next = gdf_pkg::ST_DIV_CHECK;
            gdf_pkg::ST_DIV_CHECK: state_next = gdf_pkg::ST_DIV_START;
            gdf_pkg::ST_TAIL:      state_next = gdf_pkg::ST_SORT;
            gdf_pkg::ST_SORT:
            begin
                if (!status.need_merge)
                    state_next = gdf_pkg::ST_ASSIGN;
                else if (status.sort_done)
                    state_next = gdf_pkg::ST_MERGE;
            end
            gdf_pkg::ST_MERGE:     state_next = gdf_pkg::ST_SORT;
            gdf_pkg::ST_ASSIGN:    state_next = gdf_pkg::ST_OUT;
            gdf_pkg::ST_OUT:       if (out_fire) state_next = gdf_pkg::ST_IDLE;
            default:               state_next = gdf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            gdf_pkg::ST_IDLE:      cmd.load = in_fire;
            gdf_pkg::ST_DIV_START: cmd.div_start = !status.trial_done;
            gdf_pkg::ST_DIV_CHECK:
            begin
                cmd.div_accept = status.divides;
                cmd.div_next   = !status.divides;
            end
            gdf_pkg::ST_TAIL:
            begin
                cmd.push_tail  = status.tail_needed;
                cmd.sort_reset = 1'b1;
            end
            gdf_pkg::ST_SORT:      cmd.sort_step = status.need_merge && !status.sort_done;
            gdf_pkg::ST_MERGE:
            begin
                cmd.merge      = 1'b1;
                cmd.sort_reset = 1'b1;
            end
            gdf_pkg::ST_ASSIGN:    cmd.assign_dims = 1'b1;
            gdf_pkg::ST_OUT:       cmd.out_valid = 1'b1;
            default:               cmd = '0;
        endcase
    end

    assign idle = (state_reg == gdf_pkg::ST_IDLE);

    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == gdf_pkg::ST_DIV_START) else $error("accept not taken");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |=> idle) else $error("no return to idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.merge, cmd.sort_step, cmd.div_start, cmd.load}))
        else $error("conflicting commands");
endmodule

// ----- design/grid_decomposition_factorizer.sv -----
// Top level of the grid decomposition factorizer.
// channel | dir | tdata fields (low bit up)
// s_axis  | in  | subdomain_count[15:0], subdivide_mask[18:16], zero pad to 24
// m_axis  | out | parts_x[15:0], parts_y[31:16], parts_z[47:32]
// One transaction at a time; each divisor trial runs a 16-bit bit-serial restoring divider,
// then the factor list is sorted and merged to fit the mask. rst_n clears control state
// asynchronously. A result holds in m_axis_tdata until taken; s_axis_tready is high
// only while idle.
module grid_decomposition_factorizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // subdomain_count, subdivide_mask
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // parts_x, parts_y, parts_z
);
    gdf_pkg::cmd_t    cmd;
    gdf_pkg::status_t status;
    logic idle;
    logic in_fire, out_fire;

    assign s_axis_tready = idle;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = cmd.out_valid;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    gdf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_fire (out_fire),
        .status   (status),
        .cmd      (cmd),
        .idle     (idle)
    );

    logic unused_pad;
    assign unused_pad = ^s_axis_tdata[23:19];

    gdf_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .count_in (s_axis_tdata[gdf_pkg::COUNT_WIDTH-1:0]),
        .mask_in  (s_axis_tdata[18:16]),
        .parts    (m_axis_tdata)
    );
endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the grid decomposition factorizer stream block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;

    typedef struct packed {
        logic [15:0] z;
        logic [15:0] y;
        logic [15:0] x;
    } parts_t;

    parts_t expected_mem [0:255];
    int     exp_wr;
    int     exp_rd;
    int     errors;
    int     sent_items;
    int     got_results;
    int     send_idle_pct;
    int     take_stall_pct;

    grid_decomposition_factorizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Prime factorization, then merge the two smallest until the list fits the mask.
    function automatic parts_t split_count(logic [15:0] count, logic [2:0] mask);
        longint unsigned fac[16];
        longint unsigned n;
        longint unsigned dv;
        longint unsigned tmp;
        int              nf;
        int              hd;
        int              ndim;
        int              a;
        int              b;
        logic [15:0]     res[3];
        parts_t          p;
        nf = 0;
        hd = 0;
        n = (count == 0) ? 1 : count;
        while (n[0] == 1'b0)
        begin
            fac[nf] = 2;
            nf++;
            n = n >> 1;
        end
        for (dv = 3; dv * dv <= n; dv += 2)
        begin
            while (n % dv == 0)
            begin
                fac[nf] = dv;
                nf++;
                n = n / dv;
            end
        end
        if (n > 1)
        begin
            fac[nf] = n;
            nf++;
        end
        ndim = mask[0] + mask[1] + mask[2];
        for (a = 0; a < 3; a++)
            res[a] = 16'd1;
        if (ndim != 0)
        begin
            while (nf - hd > ndim)
            begin
                for (a = hd + 1; a < nf; a++)
                begin
                    tmp = fac[a];
                    b = a;
                    while (b > hd && fac[b-1] > tmp)
                    begin
                        fac[b] = fac[b-1];
                        b--;
                    end
                    fac[b] = tmp;
                end
                fac[hd+1] = fac[hd+1] * fac[hd];
                hd++;
            end
            for (a = 0; a < 3; a++)
            begin
                if (hd < nf && mask[a])
                begin
                    res[a] = fac[hd][15:0];
                    hd++;
                end
            end
        end
        p.x = res[0];
        p.y = res[1];
        p.z = res[2];
        return p;
    endfunction

    // tvalid stays up after a transaction until the next call drives new data or idles
    task automatic send_request(logic [15:0] count, logic [2:0] mask);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 24'($urandom) & 24'h7FFFFF;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, mask, count};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_mem[exp_wr % 256] = split_count(count, mask);
        exp_wr++;
        sent_items++;
    endtask

    // Result checker; receiver stall is randomized each cycle.
    always @(posedge clk)
    begin
        parts_t got;
        parts_t exp_p;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            got_results++;
            if (exp_wr == exp_rd)
            begin
                $display("%0t: unexpected result %h", $realtime, m_axis_tdata);
                errors++;
            end
            else
            begin
                exp_p = expected_mem[exp_rd % 256];
                exp_rd++;
                if (got.x !== exp_p.x)
                begin
                    $display("%0t: parts_x exp %0d got %0d", $realtime, exp_p.x, got.x);
                    errors++;
                end
                if (got.y !== exp_p.y)
                begin
                    $display("%0t: parts_y exp %0d got %0d", $realtime, exp_p.y, got.y);
                    errors++;
                end
                if (got.z !== exp_p.z)
                begin
                    $display("%0t: parts_z exp %0d got %0d", $realtime, exp_p.z, got.z);
                    errors++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= take_stall_pct);
    end

    task automatic test_directed();
        logic [2:0] m;
        send_request(16'd0, 3'b111);
        send_request(16'd1, 3'b011);
        send_request(16'd12, 3'b000);
        send_request(16'd65535, 3'b111);
        send_request(16'd65521, 3'b111);
        send_request(16'd32768, 3'b111);
        send_request(16'd32768, 3'b101);
        send_request(16'd2, 3'b111);
        send_request(16'd6, 3'b100);
        send_request(16'd30, 3'b010);
        send_request(16'd360, 3'b111);
        send_request(16'd49152, 3'b110);
        send_request(16'd65025, 3'b011);
        send_request(16'd43690, 3'b111);
        send_request(16'd21845, 3'b001);
        for (int i = 0; i < 8; i++)
        begin
            m = 3'(i);
            send_request(16'd210, m);
        end
    endtask

    task automatic test_random(int count_items);
        logic [15:0] c;
        for (int i = 0; i < count_items; i++)
        begin
            case ($urandom_range(3))
                0: c = 16'($urandom);
                1: c = 16'($urandom_range(64));
                2: c = 16'd1 << $urandom_range(15);
                default: c = 16'($urandom_range(4096));
            endcase
            send_request(c, 3'($urandom_range(7)));
        end
    endtask

    task automatic test_idling();
        send_idle_pct = 0;  take_stall_pct = 0;  test_random(30);
        send_idle_pct = 67; take_stall_pct = 0;  test_random(30);
        send_idle_pct = 0;  take_stall_pct = 67; test_random(30);
        send_idle_pct = 35; take_stall_pct = 35; test_random(30);
    endtask

    initial
    begin
        errors = 0;
        sent_items = 0;
        got_results = 0;
        exp_wr = 0;
        exp_rd = 0;
        send_idle_pct = 0;
        take_stall_pct = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_idling();
        s_axis_tvalid <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Covered %0d requests, %0d results: edge counts, all masks, random counts.",
                 sent_items, got_results);
        if (errors == 0 && exp_wr == exp_rd)
            $display("** grid_decomposition_factorizer: PASSED **");
        else
            $display("** grid_decomposition_factorizer: FAILED **");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Timeout with %0d results outstanding", exp_wr - exp_rd);
        $display("** grid_decomposition_factorizer: FAILED **");
        $finish;
    end
endmodule

// ----- files.f -----
design/gdf_pkg.sv
design/gdf_datapath.sv
design/gdf_ctrl.sv
design/grid_decomposition_factorizer.sv
verif/tb.sv
